// File: sv/assert_macros.svh
// Assertion macros used by the checker file mhpq_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MHPQ_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: %m");

// Next-cycle implication.
`define MHPQ_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: %m");

`endif

// File: sv/mhpq_pkg.sv
// Types and constants of the min-heap priority queue.
`timescale 1ns / 1ps

package mhpq_pkg;

   localparam int CAPACITY_DEFAULT     = 64;
   localparam int PAYLOAD_BITS_DEFAULT = 32;
   localparam int LEVEL_BITS           = 16;
   localparam int PAYLOAD_FIELD_BITS   = 32;
   localparam int COUNT_FIELD_BITS     = 7;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic                                func;
      logic signed [LEVEL_BITS-1:0]        level;
      logic [PAYLOAD_FIELD_BITS-1:0]       payload;
   } req_type;

   typedef struct packed {
      status_type                          status;
      logic signed [LEVEL_BITS-1:0]        out_level;
      logic [PAYLOAD_FIELD_BITS-1:0]       out_payload;
      logic [COUNT_FIELD_BITS-1:0]         count;
   } rsp_type;

   typedef enum logic [2:0] {
      RD_PARENT = 3'd0,
      RD_ROOT   = 3'd1,
      RD_TAIL   = 3'd2,
      RD_LEFT   = 3'd3,
      RD_RIGHT  = 3'd4
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_MOVING = 2'd0,
      WR_RDATA  = 2'd1,
      WR_CHILD  = 2'd2
   } wr_sel_type;

   typedef enum logic [1:0] {
      HOLE_HOLD   = 2'd0,
      HOLE_PARENT = 2'd1,
      HOLE_KID    = 2'd2,
      HOLE_ROOT   = 2'd3
   } hole_sel_type;

   typedef struct packed {
      logic         ld_req;
      logic         cnt_inc;
      logic         cnt_dec;
      logic         rd_en;
      rd_sel_type   rd_sel;
      logic         wr_en;
      wr_sel_type   wr_sel;
      hole_sel_type hole_sel;
      logic         cap_root;
      logic         cap_moving;
      logic         cap_left;
      logic         pick;
      logic         emit;
      status_type   code;
   } ctl_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic at_root;
      logic up_less;
      logic left_in;
      logic right_in;
      logic stay_down;
   } dp_stat_type;

endpackage

// File: sv/mhpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mhpq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: sv/mhpq_dpath.sv
// Datapath: heap store, moving entry, hole and child registers, result register.
`timescale 1ns / 1ps

module mhpq_dpath #(
   parameter int CAPACITY     = mhpq_pkg::CAPACITY_DEFAULT,
   parameter int PAYLOAD_BITS = mhpq_pkg::PAYLOAD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mhpq_pkg::req_type     req_word,
   input  mhpq_pkg::ctl_cmd_type cmd,
   output mhpq_pkg::dp_stat_type stat,
   output logic                  rsp_strobe,
   output mhpq_pkg::rsp_type     rsp_word
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int KW = AW + 2;
   localparam int LW = mhpq_pkg::LEVEL_BITS;
   localparam int PW = PAYLOAD_BITS;
   localparam int EW = LW + PW;

   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] hole_ff, hole_in;
   logic [AW-1:0] kid_ff, kid_in;
   logic [EW-1:0] moving_ff, moving_in;
   logic [EW-1:0] child_ff, child_in;
   logic [EW-1:0] root_ff, root_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   mhpq_pkg::rsp_type rsp_ff, rsp_in;

   logic [KW-1:0] left_idx, right_idx, count_k;
   logic [AW-1:0] parent_idx, tail_idx, rd_addr;
   logic [EW-1:0] rd_data, wr_data;
   logic signed [LW-1:0] lev_rd, lev_mov, lev_child;

   assign left_idx   = KW'({hole_ff, 1'b1});
   assign right_idx  = left_idx + KW'(1);
   assign count_k    = KW'(count_ff);
   assign parent_idx = AW'((hole_ff - AW'(1)) >> 1);
   assign tail_idx   = AW'(count_ff - CW'(1));

   assign lev_rd    = $signed(rd_data[EW-1 -: LW]);
   assign lev_mov   = $signed(moving_ff[EW-1 -: LW]);
   assign lev_child = $signed(child_ff[EW-1 -: LW]);

   assign stat.full      = (count_ff == CW'(CAPACITY));
   assign stat.empty     = (count_ff == '0);
   assign stat.at_root   = (hole_ff == '0);
   assign stat.up_less   = (lev_mov < lev_rd);
   assign stat.left_in   = (left_idx < count_k);
   assign stat.right_in  = (right_idx < count_k);
   assign stat.stay_down = (lev_mov <= lev_child);

   always_comb begin
      case (cmd.rd_sel)
         mhpq_pkg::RD_PARENT: rd_addr = parent_idx;
         mhpq_pkg::RD_ROOT:   rd_addr = '0;
         mhpq_pkg::RD_TAIL:   rd_addr = tail_idx;
         mhpq_pkg::RD_LEFT:   rd_addr = AW'(left_idx);
         mhpq_pkg::RD_RIGHT:  rd_addr = AW'(right_idx);
         default:             rd_addr = '0;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         mhpq_pkg::WR_MOVING: wr_data = moving_ff;
         mhpq_pkg::WR_RDATA:  wr_data = rd_data;
         mhpq_pkg::WR_CHILD:  wr_data = child_ff;
         default:             wr_data = moving_ff;
      endcase
   end

   mhpq_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (hole_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in      = count_ff;
      hole_in       = hole_ff;
      kid_in        = kid_ff;
      moving_in     = moving_ff;
      child_in      = child_ff;
      root_in       = root_ff;
      rsp_strobe_in = cmd.emit;
      rsp_in        = rsp_ff;

      if (cmd.ld_req) begin
         moving_in = {req_word.level, PW'(req_word.payload)};
         root_in   = '0;
         hole_in   = AW'(count_ff);
      end
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
      case (cmd.hole_sel)
         mhpq_pkg::HOLE_PARENT: hole_in = parent_idx;
         mhpq_pkg::HOLE_KID:    hole_in = kid_ff;
         mhpq_pkg::HOLE_ROOT:   hole_in = '0;
         default:               ;
      endcase
      if (cmd.cap_root) begin
         root_in = rd_data;
      end
      if (cmd.cap_moving) begin
         moving_in = rd_data;
      end
      if (cmd.cap_left) begin
         child_in = rd_data;
         kid_in   = AW'(left_idx);
      end
      if (cmd.pick && (lev_rd < lev_child)) begin
         child_in = rd_data;
         kid_in   = kid_ff + AW'(1);
      end
      if (cmd.emit) begin
         rsp_in.status = cmd.code;
         rsp_in.count  = mhpq_pkg::COUNT_FIELD_BITS'(count_ff);
         if (cmd.code == mhpq_pkg::ST_OK) begin
            rsp_in.out_level   = $signed(root_ff[EW-1 -: LW]);
            rsp_in.out_payload = mhpq_pkg::PAYLOAD_FIELD_BITS'(root_ff[PW-1:0]);
         end else begin
            rsp_in.out_level   = '0;
            rsp_in.out_payload = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      hole_ff   <= hole_in;
      kid_ff    <= kid_in;
      moving_ff <= moving_in;
      child_ff  <= child_in;
      root_ff   <= root_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// File: sv/mhpq_ctrl.sv
// Controller: sequences push sift-up and pop sift-down over the heap store.
`timescale 1ns / 1ps

module mhpq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_func,
   input  mhpq_pkg::dp_stat_type stat,
   output logic                  busy,
   output mhpq_pkg::ctl_cmd_type cmd
);

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_UP_RD    = 10'b00_0000_0010,
      S_UP_CMP   = 10'b00_0000_0100,
      S_POP_ROOT = 10'b00_0000_1000,
      S_POP_TAIL = 10'b00_0001_0000,
      S_POP_LOAD = 10'b00_0010_0000,
      S_DN_LEFT  = 10'b00_0100_0000,
      S_DN_RIGHT = 10'b00_1000_0000,
      S_DN_PICK  = 10'b01_0000_0000,
      S_DN_CMP   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.code = mhpq_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.ld_req = 1'b1;
               if (req_func == mhpq_pkg::FUNC_POP) begin
                  if (stat.empty) begin
                     cmd.emit = 1'b1;
                     cmd.code = mhpq_pkg::ST_EMPTY;
                  end else begin
                     state_in = S_POP_ROOT;
                  end
               end else begin
                  if (stat.full) begin
                     cmd.emit = 1'b1;
                     cmd.code = mhpq_pkg::ST_FULL;
                  end else begin
                     cmd.cnt_inc = 1'b1;
                     state_in    = S_UP_RD;
                  end
               end
            end
         end
         S_UP_RD: begin
            if (stat.at_root) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = mhpq_pkg::WR_MOVING;
               cmd.emit   = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = mhpq_pkg::RD_PARENT;
               state_in   = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            cmd.wr_en = 1'b1;
            if (stat.up_less) begin
               cmd.wr_sel   = mhpq_pkg::WR_RDATA;
               cmd.hole_sel = mhpq_pkg::HOLE_PARENT;
               state_in     = S_UP_RD;
            end else begin
               cmd.wr_sel = mhpq_pkg::WR_MOVING;
               cmd.emit   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_POP_ROOT: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = mhpq_pkg::RD_ROOT;
            state_in   = S_POP_TAIL;
         end
         S_POP_TAIL: begin
            cmd.cap_root = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = mhpq_pkg::RD_TAIL;
            state_in     = S_POP_LOAD;
         end
         S_POP_LOAD: begin
            cmd.cap_moving = 1'b1;
            cmd.cnt_dec    = 1'b1;
            cmd.hole_sel   = mhpq_pkg::HOLE_ROOT;
            state_in       = S_DN_LEFT;
         end
         S_DN_LEFT: begin
            if (stat.left_in) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = mhpq_pkg::RD_LEFT;
               state_in   = S_DN_RIGHT;
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = mhpq_pkg::WR_MOVING;
               cmd.emit   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_DN_RIGHT: begin
            cmd.cap_left = 1'b1;
            if (stat.right_in) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = mhpq_pkg::RD_RIGHT;
               state_in   = S_DN_PICK;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_PICK: begin
            cmd.pick = 1'b1;
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            cmd.wr_en = 1'b1;
            if (stat.stay_down) begin
               cmd.wr_sel = mhpq_pkg::WR_MOVING;
               cmd.emit   = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.wr_sel   = mhpq_pkg::WR_CHILD;
               cmd.hole_sel = mhpq_pkg::HOLE_KID;
               state_in     = S_DN_LEFT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: sv/min_heap_priority_queue_unit.sv
// Top level of the min-heap priority queue.
`timescale 1ns / 1ps
//
// Request: a word (func, level, payload) is taken at a clock edge with start
// high and busy low. func selects push (store entry) or pop (remove minimum).
// Response: each request gives exactly one word on rsp_word, valid for the
// single cycle in which rsp_strobe is high: status, popped level and payload
// (zero unless a pop succeeds) and the entry count after the operation.
// The receiver cannot stall; the word must be taken in that cycle.
// Timing: a refused push or a pop on an empty queue answers in the cycle after
// acceptance. A push climbs one level at a time, reading the parent and then
// comparing and writing; a pop reads root and tail, loads the tail entry, then
// descends level by level (left read, right read, pick, compare; right read
// and pick only where a right child exists).
// Each store read is its own step, since the heap store has a single read port.
// busy stays high until the final store write; the next request may be taken
// in the cycle that shows the response.
// Reset clears the entry count and the controller; the store is not cleared.

module min_heap_priority_queue_unit #(
   parameter int CAPACITY     = mhpq_pkg::CAPACITY_DEFAULT,
   parameter int PAYLOAD_BITS = mhpq_pkg::PAYLOAD_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mhpq_pkg::req_type req_word,
   output logic              rsp_strobe,
   output mhpq_pkg::rsp_type rsp_word
);

   mhpq_pkg::ctl_cmd_type cmd;
   mhpq_pkg::dp_stat_type stat;

   mhpq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_word.func),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   mhpq_dpath #(
      .CAPACITY     (CAPACITY),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

// File: sv/mhpq_chk.sv
// Port-level checker for the min-heap priority queue, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mhpq_chk (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input mhpq_pkg::rsp_type rsp_word
);

   // accepted word is either in work or answered next cycle
   `MHPQ_ASSERT_NXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_strobe)

   // work never stalls without an answer
   `MHPQ_ASSERT_NXT(a_busy_progress, clock, reset, busy, busy || rsp_strobe)

   `MHPQ_ASSERT_IMP(a_err_zero, clock, reset,
      rsp_strobe && (rsp_word.status != mhpq_pkg::ST_OK),
      (rsp_word.out_level == '0) && (rsp_word.out_payload == '0))

   `MHPQ_ASSERT_IMP(a_empty_count, clock, reset,
      rsp_strobe && (rsp_word.status == mhpq_pkg::ST_EMPTY), rsp_word.count == '0)

endmodule

bind min_heap_priority_queue_unit mhpq_chk u_mhpq_chk (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);
